// ===== rtl/tvf_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle validity filter package
// Shared constants, configuration register codes, drop reason codes and the
// control word that travels with each face through the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tvf_pkg;

  // Default field widths.
  localparam int unsigned COORD_BITS_DEF = 24;
  localparam int unsigned INDEX_BITS_DEF = 24;

  // Configuration port geometry.
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned VCOUNT_W   = 25;
  localparam int unsigned ASPECT_W   = 16;
  localparam int unsigned ASPSQ_W    = 2 * ASPECT_W;

  // Register reset values.
  localparam logic                  FILTER_EN_RST = 1'b1;
  localparam logic [VCOUNT_W-1:0]   VCOUNT_RST    = '0;
  localparam logic                  DEGEN_EN_RST  = 1'b1;
  localparam logic [ASPECT_W-1:0]   ASPECT_RST    = 16'd2560;
  localparam logic [ASPSQ_W-1:0]    ASPSQ_RST     = ASPSQ_W'(ASPECT_RST * ASPECT_RST);
  localparam logic [CFG_DATA_W-1:0] MIN_AREA_RST  = 32'd282;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_EN  = 3'd0,
    CFG_VCOUNT     = 3'd1,
    CFG_DEGEN_EN   = 3'd2,
    CFG_MAX_ASPECT = 3'd3,
    CFG_MIN_AREA   = 3'd4
  } cfg_reg_e;

  // Drop reasons reported with every face.
  typedef enum logic [2:0] {
    REASON_KEEP   = 3'd0,
    REASON_RANGE  = 3'd1,
    REASON_REPEAT = 3'd2,
    REASON_TINY   = 3'd3,
    REASON_THIN   = 3'd4
  } reason_e;

  // Verdict from the index checks, plus whether the geometry tests decide.
  typedef struct packed {
    logic    geo_en;
    reason_e pre_reason;
  } face_ctl_t;

endpackage

// ===== rtl/tvf_geom.sv =====
// ----------------------------------------------------------------------------
// Triangle validity filter: geometry front end
// Three pipeline stages: index checks and edge vectors, cross and edge
// products, then cross-product magnitudes and squared edge lengths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tvf_geom
  import tvf_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [2:0][INDEX_BITS-1:0]          idx_i,
  input  logic [8:0][COORD_BITS-1:0]          coord_i,
  input  logic                                filter_en_i,
  input  logic [VCOUNT_W-1:0]                 vcount_i,
  input  logic                                degen_en_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [2:0][INDEX_BITS-1:0]          idx_o,
  output face_ctl_t                           ctl_o,
  output logic [2:0][2*COORD_BITS:0]          mag_o,
  output logic [2:0][2*COORD_BITS+1:0]        edge_o
);

  localparam int unsigned DW   = COORD_BITS + 1;
  localparam int unsigned PW   = 2 * DW;
  localparam int unsigned EW   = 2 * COORD_BITS;
  localparam int unsigned MW   = 2 * COORD_BITS + 1;
  localparam int unsigned LW   = 2 * COORD_BITS + 2;
  localparam int unsigned CMPW = (INDEX_BITS > VCOUNT_W) ? INDEX_BITS : VCOUNT_W;

  // Stage valids and the ready chain.
  logic [2:0] v_q;
  logic [2:0] rdy;

  assign rdy[2]      = !v_q[2] || out_ready_i;
  assign rdy[1]      = !v_q[1] || rdy[2];
  assign rdy[0]      = !v_q[0] || rdy[1];
  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
    end
  end

  // Stage 1: index checks and the edge vectors ab, ac, bc.
  logic [2:0][INDEX_BITS-1:0] idx1_q, idx2_q, idx3_q;
  face_ctl_t                  ctl1_d, ctl1_q, ctl2_q, ctl3_q;
  logic [8:0][DW-1:0]         d1_d, d1_q;

  always_comb begin
    logic range_bad;
    logic repeat_bad;
    range_bad = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (CMPW'(idx_i[k]) >= CMPW'(vcount_i)) range_bad = 1'b1;
    end
    repeat_bad = (idx_i[0] == idx_i[1]) || (idx_i[1] == idx_i[2]) ||
                 (idx_i[0] == idx_i[2]);
    ctl1_d.geo_en     = 1'b0;
    ctl1_d.pre_reason = REASON_KEEP;
    // An empty mesh passes every face, as with the filter off.
    if (!filter_en_i || (vcount_i == '0)) begin
      ctl1_d.pre_reason = REASON_KEEP;
    end else if (range_bad) begin
      ctl1_d.pre_reason = REASON_RANGE;
    end else if (repeat_bad) begin
      ctl1_d.pre_reason = REASON_REPEAT;
    end else begin
      ctl1_d.geo_en = degen_en_i;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d1_d[k]     = DW'($signed(coord_i[3 + k])) - DW'($signed(coord_i[k]));
      d1_d[3 + k] = DW'($signed(coord_i[6 + k])) - DW'($signed(coord_i[k]));
      d1_d[6 + k] = DW'($signed(coord_i[6 + k])) - DW'($signed(coord_i[3 + k]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      idx1_q <= idx_i;
      ctl1_q <= ctl1_d;
      d1_q   <= d1_d;
    end
  end

  // Stage 2: the six cross-product terms and nine squared components.
  logic [5:0][PW-1:0] p2_d, p2_q;
  logic [8:0][EW-1:0] e2_d, e2_q;

  always_comb begin
    logic signed [DW-1:0] ds [9];
    logic signed [PW-1:0] sq;
    for (int k = 0; k < 9; k++) ds[k] = $signed(d1_q[k]);
    // Component order in ds: abx aby abz acx acy acz bcx bcy bcz.
    p2_d[0] = ds[1] * ds[5];
    p2_d[1] = ds[2] * ds[4];
    p2_d[2] = ds[2] * ds[3];
    p2_d[3] = ds[0] * ds[5];
    p2_d[4] = ds[0] * ds[4];
    p2_d[5] = ds[1] * ds[3];
    for (int k = 0; k < 9; k++) begin
      sq      = ds[k] * ds[k];
      e2_d[k] = sq[EW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      idx2_q <= idx1_q;
      ctl2_q <= ctl1_q;
      p2_q   <= p2_d;
      e2_q   <= e2_d;
    end
  end

  // Stage 3: cross-product magnitudes and squared edge lengths.
  logic [2:0][MW-1:0] mag3_d, mag3_q;
  logic [2:0][LW-1:0] len3_d, len3_q;

  always_comb begin
    logic [PW-1:0] pos;
    logic [PW-1:0] neg;
    for (int k = 0; k < 3; k++) begin
      pos       = p2_q[2 * k] - p2_q[2 * k + 1];
      neg       = p2_q[2 * k + 1] - p2_q[2 * k];
      mag3_d[k] = pos[PW-1] ? neg[MW-1:0] : pos[MW-1:0];
      len3_d[k] = LW'(e2_q[3 * k]) + LW'(e2_q[3 * k + 1]) + LW'(e2_q[3 * k + 2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      idx3_q <= idx2_q;
      ctl3_q <= ctl2_q;
      mag3_q <= mag3_d;
      len3_q <= len3_d;
    end
  end

  assign idx_o  = idx3_q;
  assign ctl_o  = ctl3_q;
  assign mag_o  = mag3_q;
  assign edge_o = len3_q;

endmodule

// ===== rtl/tvf_square.sv =====
// ----------------------------------------------------------------------------
// Triangle validity filter: wide squares
// Three pipeline stages that square the cross-product magnitudes by halves
// and sum them into the squared doubled area, and that pick the longest
// edge and square it the same way.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tvf_square
  import tvf_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0][INDEX_BITS-1:0]    idx_i,
  input  face_ctl_t                     ctl_i,
  input  logic [2:0][2*COORD_BITS:0]    mag_i,
  input  logic [2:0][2*COORD_BITS+1:0]  edge_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0][INDEX_BITS-1:0]    idx_o,
  output face_ctl_t                     ctl_o,
  output logic [4*COORD_BITS+3:0]       area_o,
  output logic [4*COORD_BITS+3:0]       lng2_o
);

  localparam int unsigned MW  = 2 * COORD_BITS + 1;
  localparam int unsigned H   = COORD_BITS + 1;
  localparam int unsigned MHW = MW - H;
  localparam int unsigned SW  = 2 * MW;
  localparam int unsigned AW  = SW + 2;
  localparam int unsigned LW  = 2 * COORD_BITS + 2;
  localparam int unsigned H2  = COORD_BITS + 1;
  localparam int unsigned LHW = LW - H2;
  localparam int unsigned L2W = 2 * LW;

  // Stage valids and the ready chain.
  logic [2:0] v_q;
  logic [2:0] rdy;

  assign rdy[2]      = !v_q[2] || out_ready_i;
  assign rdy[1]      = !v_q[1] || rdy[2];
  assign rdy[0]      = !v_q[0] || rdy[1];
  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
    end
  end

  logic [2:0][INDEX_BITS-1:0] idx4_q, idx5_q, idx6_q;
  face_ctl_t                  ctl4_q, ctl5_q, ctl6_q;

  // Stage 4: partial products of each magnitude, longest edge.
  logic [2:0][2*MHW-1:0] hh4_d, hh4_q;
  logic [2:0][MW-1:0]    hl4_d, hl4_q;
  logic [2:0][2*H-1:0]   ll4_d, ll4_q;
  logic [LW-1:0]         lng4_d, lng4_q;

  always_comb begin
    logic [MHW-1:0] xh;
    logic [H-1:0]   xl;
    logic [LW-1:0]  l01;
    for (int k = 0; k < 3; k++) begin
      xh       = mag_i[k][MW-1:H];
      xl       = mag_i[k][H-1:0];
      hh4_d[k] = xh * xh;
      hl4_d[k] = xh * xl;
      ll4_d[k] = xl * xl;
    end
    l01    = (edge_i[0] >= edge_i[1]) ? edge_i[0] : edge_i[1];
    lng4_d = (l01 >= edge_i[2]) ? l01 : edge_i[2];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      idx4_q <= idx_i;
      ctl4_q <= ctl_i;
      hh4_q  <= hh4_d;
      hl4_q  <= hl4_d;
      ll4_q  <= ll4_d;
      lng4_q <= lng4_d;
    end
  end

  // Stage 5: full squares of the magnitudes, partial products of the edge.
  logic [2:0][SW-1:0] sq5_d, sq5_q;
  logic [2*LHW-1:0]   lhh5_d, lhh5_q;
  logic [LW-1:0]      lhl5_d, lhl5_q;
  logic [2*H2-1:0]    lll5_d, lll5_q;

  always_comb begin
    logic [LHW-1:0] yh;
    logic [H2-1:0]  yl;
    for (int k = 0; k < 3; k++) begin
      sq5_d[k] = (SW'(hh4_q[k]) << (2 * H)) + (SW'(hl4_q[k]) << (H + 1)) +
                 SW'(ll4_q[k]);
    end
    yh     = lng4_q[LW-1:H2];
    yl     = lng4_q[H2-1:0];
    lhh5_d = yh * yh;
    lhl5_d = yh * yl;
    lll5_d = yl * yl;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      idx5_q <= idx4_q;
      ctl5_q <= ctl4_q;
      sq5_q  <= sq5_d;
      lhh5_q <= lhh5_d;
      lhl5_q <= lhl5_d;
      lll5_q <= lll5_d;
    end
  end

  // Stage 6: squared doubled area and squared longest edge.
  logic [AW-1:0]  area6_d, area6_q;
  logic [L2W-1:0] lng6_d, lng6_q;

  always_comb begin
    area6_d = AW'(sq5_q[0]) + AW'(sq5_q[1]) + AW'(sq5_q[2]);
    lng6_d  = (L2W'(lhh5_q) << (2 * H2)) + (L2W'(lhl5_q) << (H2 + 1)) + L2W'(lll5_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      idx6_q  <= idx5_q;
      ctl6_q  <= ctl5_q;
      area6_q <= area6_d;
      lng6_q  <= lng6_d;
    end
  end

  assign idx_o  = idx6_q;
  assign ctl_o  = ctl6_q;
  assign area_o = area6_q;
  assign lng2_o = lng6_q;

endmodule

// ===== rtl/tvf_aspect.sv =====
// ----------------------------------------------------------------------------
// Triangle validity filter: thresholds and verdict
// Three pipeline stages: area threshold and partial products of the area by
// the squared aspect limit, the summed aspect product, then the aspect
// compare and the verdict in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tvf_aspect
  import tvf_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0][INDEX_BITS-1:0]  idx_i,
  input  face_ctl_t                   ctl_i,
  input  logic [4*COORD_BITS+3:0]     area_i,
  input  logic [4*COORD_BITS+3:0]     lng2_i,
  input  logic [CFG_DATA_W-1:0]       min_area_i,
  input  logic [ASPSQ_W-1:0]          aspect_sq_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0][INDEX_BITS-1:0]  idx_o,
  output logic                        keep_o,
  output reason_e                     reason_o
);

  localparam int unsigned AW    = 4 * COORD_BITS + 4;
  localparam int unsigned L2W   = 4 * COORD_BITS + 4;
  localparam int unsigned RW    = L2W + 16;
  localparam int unsigned K     = (AW + 31) / 32;
  localparam int unsigned NEVEN = (K + 1) / 2;
  localparam int unsigned NODD  = K / 2;
  localparam int unsigned XW    = 32 * (K + 2);

  // Stage valids and the ready chain; the last stage is the output register.
  logic [2:0] v_q;
  logic [2:0] rdy;

  assign rdy[2]      = !v_q[2] || out_ready_i;
  assign rdy[1]      = !v_q[1] || rdy[2];
  assign rdy[0]      = !v_q[0] || rdy[1];
  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
    end
  end

  logic [2:0][INDEX_BITS-1:0] idx7_q, idx8_q, idx9_q;
  face_ctl_t                  ctl7_q, ctl8_q;

  // Stage 7: area threshold and 32-bit slices of the area times the limit.
  logic [K-1:0][63:0] pp7_d, pp7_q;
  logic [RW-1:0]      rhs7_d, rhs7_q, rhs8_q;
  logic               tiny7_d, tiny7_q, tiny8_q;
  logic               thin_en7_d, thin_en7_q, thin_en8_q;

  always_comb begin
    logic [32*K-1:0] area_pad;
    area_pad = (32 * K)'(area_i);
    for (int i = 0; i < K; i++) begin
      pp7_d[i] = area_pad[32 * i +: 32] * aspect_sq_i;
    end
    tiny7_d    = area_i <= AW'(min_area_i);
    thin_en7_d = |lng2_i;
    rhs7_d     = {lng2_i, 16'b0};
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      idx7_q     <= idx_i;
      ctl7_q     <= ctl_i;
      pp7_q      <= pp7_d;
      rhs7_q     <= rhs7_d;
      tiny7_q    <= tiny7_d;
      thin_en7_q <= thin_en7_d;
    end
  end

  // Stage 8: even slices do not overlap, nor do odd ones, so one add sums all.
  logic [XW-1:0] lhs8_d, lhs8_q;

  always_comb begin
    logic [XW-1:0] even_v;
    logic [XW-1:0] odd_v;
    even_v = '0;
    odd_v  = '0;
    for (int j = 0; j < NEVEN; j++) even_v[64 * j +: 64] = pp7_q[2 * j];
    for (int j = 0; j < NODD; j++)  odd_v[64 * j +: 64]  = pp7_q[2 * j + 1];
    lhs8_d = even_v + (odd_v << 32);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      idx8_q     <= idx7_q;
      ctl8_q     <= ctl7_q;
      lhs8_q     <= lhs8_d;
      rhs8_q     <= rhs7_q;
      tiny8_q    <= tiny7_q;
      thin_en8_q <= thin_en7_q;
    end
  end

  // Stage 9: aspect compare and final verdict. Tiny area wins over too thin.
  reason_e reason9_d, reason9_q;
  logic    keep9_q;

  always_comb begin
    logic thin;
    thin = thin_en8_q && (lhs8_q < XW'(rhs8_q));
    priority if (!ctl8_q.geo_en) begin
      reason9_d = ctl8_q.pre_reason;
    end else if (tiny8_q) begin
      reason9_d = REASON_TINY;
    end else if (thin) begin
      reason9_d = REASON_THIN;
    end else begin
      reason9_d = REASON_KEEP;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      idx9_q    <= idx8_q;
      reason9_q <= reason9_d;
      keep9_q   <= (reason9_d == REASON_KEEP);
    end
  end

  assign idx_o    = idx9_q;
  assign keep_o   = keep9_q;
  assign reason_o = reason9_q;

endmodule

// ===== rtl/triangle_validity_filter_top.sv =====
// ----------------------------------------------------------------------------
// Triangle validity filter
// Takes one triangle per item and returns one verdict per item, one item per
// clock cycle when the output side keeps up. Every item runs through nine
// register stages, and its verdict appears once it has passed all of them;
// the ninth stage is the output register. Each stage holds its item while
// the next is full, so a stalled output fills the bubbles ahead of it before
// the input ready drops. The depth is set by the exact wide arithmetic: the
// squared cross-product norm and the squared longest edge are built from
// half-width products, and the aspect product from 32-bit slices, each in a
// stage of its own. Configuration registers are written through a plain
// write port and must only change while no item is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_validity_filter_top
  import tvf_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF,
  localparam int unsigned IN_W  = ((3 * INDEX_BITS + 9 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((3 * INDEX_BITS + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Face input.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0: index_a, index_b, index_c, ax, ay, az, bx, by, bz,
  // cx, cy, cz, zero padding.
  input  logic [IN_W-1:0]       s_axis_tdata,
  // Verdict output.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0: out_index_a, out_index_b, out_index_c, zero padding.
  output logic [OUT_W-1:0]      m_axis_tdata,
  // Fields from bit 0: keep, drop_reason.
  output logic [3:0]            m_axis_tuser
);

  // Configuration registers. The aspect limit is kept as its square.
  logic                  filter_en_q;
  logic [VCOUNT_W-1:0]   vcount_q;
  logic                  degen_en_q;
  logic [ASPSQ_W-1:0]    aspect_sq_q;
  logic [ASPSQ_W-1:0]    aspect_sq_d;
  logic [CFG_DATA_W-1:0] min_area_q;

  always_comb begin
    aspect_sq_d = cfg_wdata_i[ASPECT_W-1:0] * cfg_wdata_i[ASPECT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_en_q <= FILTER_EN_RST;
      vcount_q    <= VCOUNT_RST;
      degen_en_q  <= DEGEN_EN_RST;
      aspect_sq_q <= ASPSQ_RST;
      min_area_q  <= MIN_AREA_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_FILTER_EN:  filter_en_q <= cfg_wdata_i[0];
        CFG_VCOUNT:     vcount_q    <= cfg_wdata_i[VCOUNT_W-1:0];
        CFG_DEGEN_EN:   degen_en_q  <= cfg_wdata_i[0];
        CFG_MAX_ASPECT: aspect_sq_q <= aspect_sq_d;
        CFG_MIN_AREA:   min_area_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Unpack the input item.
  logic [2:0][INDEX_BITS-1:0] in_idx;
  logic [8:0][COORD_BITS-1:0] in_coord;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_idx[k] = s_axis_tdata[INDEX_BITS * k +: INDEX_BITS];
    end
    for (int k = 0; k < 9; k++) begin
      in_coord[k] = s_axis_tdata[3 * INDEX_BITS + COORD_BITS * k +: COORD_BITS];
    end
  end

  // Geometry front end.
  logic                         g_valid, g_ready;
  logic [2:0][INDEX_BITS-1:0]   g_idx;
  face_ctl_t                    g_ctl;
  logic [2:0][2*COORD_BITS:0]   g_mag;
  logic [2:0][2*COORD_BITS+1:0] g_edge;

  tvf_geom #(
    .COORD_BITS(COORD_BITS),
    .INDEX_BITS(INDEX_BITS)
  ) u_geom (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .idx_i      (in_idx),
    .coord_i    (in_coord),
    .filter_en_i(filter_en_q),
    .vcount_i   (vcount_q),
    .degen_en_i (degen_en_q),
    .out_valid_o(g_valid),
    .out_ready_i(g_ready),
    .idx_o      (g_idx),
    .ctl_o      (g_ctl),
    .mag_o      (g_mag),
    .edge_o     (g_edge)
  );

  // Wide squares.
  logic                       q_valid, q_ready;
  logic [2:0][INDEX_BITS-1:0] q_idx;
  face_ctl_t                  q_ctl;
  logic [4*COORD_BITS+3:0]    q_area;
  logic [4*COORD_BITS+3:0]    q_lng2;

  tvf_square #(
    .COORD_BITS(COORD_BITS),
    .INDEX_BITS(INDEX_BITS)
  ) u_square (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (g_valid),
    .in_ready_o (g_ready),
    .idx_i      (g_idx),
    .ctl_i      (g_ctl),
    .mag_i      (g_mag),
    .edge_i     (g_edge),
    .out_valid_o(q_valid),
    .out_ready_i(q_ready),
    .idx_o      (q_idx),
    .ctl_o      (q_ctl),
    .area_o     (q_area),
    .lng2_o     (q_lng2)
  );

  // Thresholds, aspect test and output register.
  logic [2:0][INDEX_BITS-1:0] out_idx;
  logic                       out_keep;
  reason_e                    out_reason;

  tvf_aspect #(
    .COORD_BITS(COORD_BITS),
    .INDEX_BITS(INDEX_BITS)
  ) u_aspect (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (q_valid),
    .in_ready_o (q_ready),
    .idx_i      (q_idx),
    .ctl_i      (q_ctl),
    .area_i     (q_area),
    .lng2_i     (q_lng2),
    .min_area_i (min_area_q),
    .aspect_sq_i(aspect_sq_q),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .idx_o      (out_idx),
    .keep_o     (out_keep),
    .reason_o   (out_reason)
  );

  assign m_axis_tdata = OUT_W'(out_idx);
  assign m_axis_tuser = {out_reason, out_keep};

`ifndef SYNTHESIS
  // The input only backs up when every stage is full and the output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while the pipeline could still advance");

  // A kept face carries no drop reason, and a dropped one always has one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tuser[3:1] == REASON_KEEP)))
    else $error("keep flag disagrees with drop reason");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Triangle validity filter testbench
// Streams faces into the filter and checks every verdict against a predictor
// that repeats the index checks and the area and aspect tests with exact
// wide integer arithmetic. A short directed part covers the corner cases;
// random phases then sweep the register settings with random idling on both
// sides, one stretch without idling and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import tvf_pkg::*;

  localparam int unsigned COORD_W     = COORD_BITS_DEF;
  localparam int unsigned INDEX_W     = INDEX_BITS_DEF;
  localparam int unsigned IN_W        = ((3 * INDEX_W + 9 * COORD_W + 7) / 8) * 8;
  localparam int unsigned OUT_W       = ((3 * INDEX_W + 7) / 8) * 8;
  localparam int unsigned WIDE        = 192;
  localparam int unsigned PIPE_DEPTH  = 9;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 90;
  localparam int          COORD_MIN   = -8388608;
  localparam int          COORD_MAX   = 8388607;

  // One face: corners ax..cz in pos[0..8], indices a..c in idx[0..2].
  typedef struct packed {
    logic [8:0][COORD_W-1:0] pos;
    logic [2:0][INDEX_W-1:0] idx;
  } face_t;

  typedef struct packed {
    logic                    keep;
    reason_e                 reason;
    logic [2:0][INDEX_W-1:0] idx;
  } verdict_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = CFG_FILTER_EN;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic [3:0]            m_axis_tuser;

  // Shadow copy of the filter registers.
  logic                  cfg_filter_en = FILTER_EN_RST;
  logic [VCOUNT_W-1:0]   cfg_vcount    = VCOUNT_RST;
  logic                  cfg_degen_en  = DEGEN_EN_RST;
  logic [ASPECT_W-1:0]   cfg_aspect    = ASPECT_RST;
  logic [CFG_DATA_W-1:0] cfg_min_area  = MIN_AREA_RST;

  face_t    face_q [$];
  verdict_t verdict_q [$];
  face_t    offered_face;
  int       tx_idle_pct = 25;
  int       rx_idle_pct = 25;
  logic     hold_go     = 1'b0;
  int       hold_left   = 0;
  int       fail_count  = 0;

  triangle_validity_filter_top #(
    .COORD_BITS(COORD_W),
    .INDEX_BITS(INDEX_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Expected drop reason of a face under the current register settings.
  function automatic reason_e classify_face(face_t f);
    logic signed [WIDE-1:0] p [9];
    logic signed [WIDE-1:0] ab [3];
    logic signed [WIDE-1:0] ac [3];
    logic signed [WIDE-1:0] bc [3];
    logic signed [WIDE-1:0] n [3];
    logic signed [WIDE-1:0] area, floor_sq, lng, len_sq, ratio;
    int k;
    if (!cfg_filter_en || cfg_vcount == 0) return REASON_KEEP;
    for (k = 0; k < 3; k++) begin
      if (f.idx[k] >= cfg_vcount) return REASON_RANGE;
    end
    if (f.idx[0] == f.idx[1] || f.idx[1] == f.idx[2] || f.idx[0] == f.idx[2]) begin
      return REASON_REPEAT;
    end
    if (!cfg_degen_en) return REASON_KEEP;
    for (k = 0; k < 9; k++) p[k] = $signed(f.pos[k]);
    for (k = 0; k < 3; k++) begin
      ab[k] = p[3 + k] - p[k];
      ac[k] = p[6 + k] - p[k];
      bc[k] = p[6 + k] - p[3 + k];
    end
    // Cross product of edges ab and ac from corner a, then its squared norm.
    n[0] = ab[1] * ac[2] - ab[2] * ac[1];
    n[1] = ab[2] * ac[0] - ab[0] * ac[2];
    n[2] = ab[0] * ac[1] - ab[1] * ac[0];
    area = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
    floor_sq = cfg_min_area;
    if (area <= floor_sq) return REASON_TINY;
    // Longest squared edge.
    lng = ab[0] * ab[0] + ab[1] * ab[1] + ab[2] * ab[2];
    len_sq = ac[0] * ac[0] + ac[1] * ac[1] + ac[2] * ac[2];
    if (len_sq > lng) lng = len_sq;
    len_sq = bc[0] * bc[0] + bc[1] * bc[1] + bc[2] * bc[2];
    if (len_sq > lng) lng = len_sq;
    if (lng != 0) begin
      ratio = cfg_aspect;
      if (area * ratio * ratio < ((lng * lng) <<< 16)) return REASON_THIN;
    end
    return REASON_KEEP;
  endfunction

  function automatic int rand_signed(int unsigned span);
    return int'($urandom_range(2 * span)) - int'(span);
  endfunction

  function automatic face_t make_face(int unsigned ia, int unsigned ib, int unsigned ic,
                                      int ax, int ay, int az, int bx, int by, int bz,
                                      int cx, int cy, int cz);
    face_t f;
    f.idx = {INDEX_W'(ic), INDEX_W'(ib), INDEX_W'(ia)};
    f.pos = {COORD_W'(cz), COORD_W'(cy), COORD_W'(cx), COORD_W'(bz), COORD_W'(by),
             COORD_W'(bx), COORD_W'(az), COORD_W'(ay), COORD_W'(ax)};
    return f;
  endfunction

  // Mostly valid faces with distinct indices, mixed with index faults, and
  // geometry ranging from arbitrary to tiny, near-collinear and coincident.
  function automatic face_t random_face();
    face_t f;
    int unsigned roll, which, k;
    int a [3];
    int b [3];
    int c [3];
    int step;
    do begin
      for (k = 0; k < 3; k++) begin
        f.idx[k] = (cfg_vcount == 0) ? INDEX_W'($urandom)
                                     : INDEX_W'($urandom_range(cfg_vcount - 1));
      end
    end while (cfg_vcount >= 3 &&
               (f.idx[0] == f.idx[1] || f.idx[1] == f.idx[2] || f.idx[0] == f.idx[2]));
    roll = $urandom_range(99);
    which = $urandom_range(2);
    if (roll < 8 && cfg_vcount <= (1 << INDEX_W) - 1) begin
      f.idx[which] = INDEX_W'($urandom_range((1 << INDEX_W) - 1, cfg_vcount));
    end else if (roll < 16) begin
      f.idx[which] = f.idx[(which + 1) % 3];
    end

    roll = $urandom_range(99);
    for (k = 0; k < 3; k++) begin
      a[k] = rand_signed(1 << 21);
      step = rand_signed(($urandom_range(1) != 0) ? (1 << 20) : 64);
      if (roll < 40) begin
        a[k] = int'($signed(COORD_W'($urandom)));
        b[k] = int'($signed(COORD_W'($urandom)));
        c[k] = int'($signed(COORD_W'($urandom)));
      end else if (roll < 60) begin
        b[k] = a[k] + rand_signed(12);
        c[k] = a[k] + rand_signed(12);
      end else if (roll < 85) begin
        b[k] = a[k] + step;
        c[k] = a[k] + step / 2 + rand_signed(2);
      end else begin
        b[k] = rand_signed(1 << 22);
        c[k] = rand_signed(1 << 22);
      end
    end
    // Coincident corners.
    if (roll >= 85) begin
      which = $urandom_range(3);
      for (k = 0; k < 3; k++) begin
        if (which == 0 || which == 3) b[k] = a[k];
        if (which == 1 || which == 3) c[k] = a[k];
        if (which == 2) c[k] = b[k];
      end
    end
    for (k = 0; k < 3; k++) begin
      f.pos[k]     = COORD_W'(a[k]);
      f.pos[3 + k] = COORD_W'(b[k]);
      f.pos[6 + k] = COORD_W'(c[k]);
    end
    return f;
  endfunction

  // Face driver: predicts each accepted item, then offers the next one.
  always @(posedge clk_i) begin
    verdict_t v;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        v.reason = classify_face(offered_face);
        v.keep   = (v.reason == REASON_KEEP);
        v.idx    = offered_face.idx;
        verdict_q.push_back(v);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (face_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          offered_face = face_q.pop_front();
          s_axis_tdata  <= IN_W'({offered_face.pos, offered_face.idx});
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output ready: random stalls, or a long hold-off on request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left <= 0;
    end else if (hold_go) begin
      m_axis_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  // Verdict monitor: compares each accepted item with the oldest expectation.
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: verdict with no face pending, expected none, actual %0h/%0h",
                 $time, m_axis_tuser, m_axis_tdata);
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        check_field("keep", want.keep, m_axis_tuser[0]);
        check_field("drop_reason", want.reason, m_axis_tuser[3:1]);
        check_field("out_index_a", want.idx[0], m_axis_tdata[INDEX_W-1:0]);
        check_field("out_index_b", want.idx[1], m_axis_tdata[2*INDEX_W-1:INDEX_W]);
        check_field("out_index_c", want.idx[2], m_axis_tdata[3*INDEX_W-1:2*INDEX_W]);
      end
    end
  end

  task automatic write_reg(input cfg_reg_e which, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= which;
    cfg_wdata_i <= value;
    case (which)
      CFG_FILTER_EN:  cfg_filter_en = value[0];
      CFG_VCOUNT:     cfg_vcount = value[VCOUNT_W-1:0];
      CFG_DEGEN_EN:   cfg_degen_en = value[0];
      CFG_MAX_ASPECT: cfg_aspect = value[ASPECT_W-1:0];
      CFG_MIN_AREA:   cfg_min_area = value;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(input logic fe, input logic [CFG_DATA_W-1:0] vc, input logic de,
                           input logic [CFG_DATA_W-1:0] asp,
                           input logic [CFG_DATA_W-1:0] floor_sq);
    write_reg(CFG_FILTER_EN, fe);
    write_reg(CFG_VCOUNT, vc);
    write_reg(CFG_DEGEN_EN, de);
    write_reg(CFG_MAX_ASPECT, asp);
    write_reg(CFG_MIN_AREA, floor_sq);
  endtask

  // Waits until every face has been offered and judged, then lets the
  // pipeline settle.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (face_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0);
    repeat (PIPE_DEPTH + 3) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned count, input int tx_pct, input int rx_pct,
                           input bit with_hold);
    @(negedge clk_i);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) face_q.push_back(random_face());
    if (with_hold) begin
      @(posedge clk_i);
      hold_go <= 1'b1;
      @(posedge clk_i);
      hold_go <= 1'b0;
    end
    wait_idle();
  endtask

  initial begin
    int ph;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // With no vertices every face passes, whatever its faults.
    @(negedge clk_i);
    face_q.push_back(make_face(5, 5, 9, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    face_q.push_back(make_face(1, 2, 3, 0, 0, 0, 16384, 0, 0, 0, 16384, 0));
    wait_idle();

    // Index faults, area and aspect cases on a small mesh.
    write_reg(CFG_VCOUNT, 16);
    write_reg(CFG_MIN_AREA, 289);
    @(negedge clk_i);
    face_q.push_back(make_face(0, 1, 2, 0, 0, 0, 16384, 0, 0, 0, 16384, 0));
    face_q.push_back(make_face(16, 1, 2, 0, 0, 0, 16384, 0, 0, 0, 16384, 0));
    face_q.push_back(make_face(20, 20, 3, 0, 0, 0, 16384, 0, 0, 0, 16384, 0));
    face_q.push_back(make_face(5, 5, 6, 0, 0, 0, 16384, 0, 0, 0, 16384, 0));
    face_q.push_back(make_face(5, 6, 6, 0, 0, 0, 16384, 0, 0, 0, 16384, 0));
    face_q.push_back(make_face(7, 8, 7, 0, 0, 0, 16384, 0, 0, 0, 16384, 0));
    face_q.push_back(make_face(1, 2, 3, 100, 200, 300, 100, 200, 300, 100, 200, 300));
    face_q.push_back(make_face(1, 2, 3, 100, 200, 300, 100, 200, 300, 900, -50, 7));
    face_q.push_back(make_face(1, 2, 3, 0, 0, 0, 1000, 2000, 3000, 2000, 4000, 6000));
    face_q.push_back(make_face(1, 2, 3, 0, 0, 0, 4194304, 0, 0, 2097152, 1, 0));
    face_q.push_back(make_face(1, 2, 3, 0, 0, 0, 1, 0, 0, 0, 17, 0));
    face_q.push_back(make_face(1, 2, 3, 0, 0, 0, 1, 0, 0, 0, 18, 0));
    face_q.push_back(make_face(15, 0, 14, COORD_MIN, COORD_MIN, COORD_MIN,
                               COORD_MAX, COORD_MIN, COORD_MIN,
                               COORD_MIN, COORD_MAX, COORD_MAX));
    wait_idle();

    // Filter off: faults are ignored.
    write_reg(CFG_FILTER_EN, 0);
    @(negedge clk_i);
    face_q.push_back(make_face(16, 1, 2, 0, 0, 0, 16384, 0, 0, 0, 16384, 0));
    face_q.push_back(make_face(3, 3, 4, 0, 0, 0, 16384, 0, 0, 0, 16384, 0));
    face_q.push_back(make_face(1, 2, 3, 7, 7, 7, 7, 7, 7, 7, 7, 7));
    wait_idle();

    // Degenerate test off: only index checks apply.
    write_reg(CFG_FILTER_EN, 1);
    write_reg(CFG_DEGEN_EN, 0);
    @(negedge clk_i);
    face_q.push_back(make_face(1, 2, 3, 7, 7, 7, 7, 7, 7, 7, 7, 7));
    face_q.push_back(make_face(3, 4, 3, 7, 7, 7, 7, 7, 7, 7, 7, 7));
    wait_idle();

    // Zero aspect drops every face with a nonzero edge; widest indices.
    write_reg(CFG_DEGEN_EN, 1);
    write_reg(CFG_MAX_ASPECT, 0);
    write_reg(CFG_VCOUNT, 1 << INDEX_W);
    @(negedge clk_i);
    face_q.push_back(make_face(24'hFFFFFF, 24'hFFFFFE, 0,
                               0, 0, 0, 16384, 0, 0, 0, 16384, 0));
    wait_idle();

    // Random phases over a sweep of register settings.
    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: configure(1, 1 << INDEX_W, 1, 2560, 282);
        1: configure(1, $urandom_range(1 << INDEX_W, 3), 1, $urandom_range(65535, 1),
                     $urandom);
        2: configure(1, 1 << INDEX_W, 1, $urandom_range(65535, 1), $urandom_range(5000));
        3: configure(1, 1 << INDEX_W, 1, 1, 0);
        4: configure(1, 1 << INDEX_W, 1, 65535, 32'hFFFFFFFF);
        5: configure(1, 1 << INDEX_W, 1, 0, 282);
        6: configure(1, 3, 1, 2560, 282);
        7: configure(1, $urandom_range(1 << INDEX_W, 1), 0, $urandom_range(65535, 1),
                     $urandom);
        8: configure(0, $urandom_range(1 << INDEX_W, 1), $urandom_range(1),
                     $urandom_range(65535, 1), $urandom);
        default: configure(1, 0, 1, 2560, 282);
      endcase
      case (ph)
        1: run_phase(PHASE_ITEMS, 0, 0, 1'b0);
        2: run_phase(PHASE_ITEMS, 0, 25, 1'b1);
        default: run_phase(PHASE_ITEMS, 25, 25, 1'b0);
      endcase
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== triangle_validity_filter_top.f =====
rtl/tvf_pkg.sv
rtl/tvf_geom.sv
rtl/tvf_square.sv
rtl/tvf_aspect.sv
rtl/triangle_validity_filter_top.sv
tb/sv/tb_top.sv
